// ----- hw/rtl/dsm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsm_pkg
// Shared sizes, operation codes and control/status bundles of the
// deduplicating stack with membership marks.
// ----------------------------------------------------------------------------
package dsm_pkg;

    // Storage sizes.
    localparam int STACK_DEPTH = 1024;
    localparam int VALUE_RANGE = 1024;

    // Fixed field widths of the item and result.
    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 10;
    localparam int LIMIT_W  = 11;
    localparam int STATUS_W = 2;
    localparam int LEVEL_W  = 11;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    // Derived internal widths.
    localparam int STK_AW  = $clog2(STACK_DEPTH);
    localparam int VAL_AW  = $clog2(VALUE_RANGE);
    localparam int FILL_W  = $clog2(STACK_DEPTH + 1);
    localparam int RANGE_W = $clog2(VALUE_RANGE + 1);
    localparam int IDX_W0  = (FILL_W > RANGE_W) ? FILL_W : RANGE_W;
    localparam int IDX_W   = (IDX_W0 > LIMIT_W) ? IDX_W0 : LIMIT_W;

    // Operation codes carried in the cmd field.
    typedef enum logic [CMD_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_INIT  = 2'd3
    } dsm_op_t;

    // Status codes reported with each result.
    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_UNDERFLOW = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;    // accept the item on the input channel
        logic lookup;  // memory read data of a push or pop is available
        logic walk;    // stepping through a clear or init walk
        logic sweep;   // clearing all marks after reset
        logic load;    // move the finished result into the output register
    } dsm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        dsm_op_t in_op;     // operation of the item at the input
        logic    fill_zero; // stack is empty
        logic    walk_done; // the walk or sweep has no step left
        logic    out_free;  // output register can take a result this cycle
    } dsm_sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/dsm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= ram_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/dsm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsm_ctrl
// Controller of the deduplicating stack: sequences the reset sweep, the
// one-step push and pop, the clear and init walks and the result hand-off.
// ----------------------------------------------------------------------------
module dsm_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire dsm_pkg::dsm_sts_t sts,
    output dsm_pkg::dsm_cmd_t      cmd
);

    typedef enum logic [4:0] {
        ST_SWEEP  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_LOOKUP = 5'b00100,
        ST_WALK   = 5'b01000,
        ST_FINISH = 5'b10000
    } dsm_state_t;

    dsm_state_t state_reg;
    dsm_state_t state_next;
    logic       take;

    assign take = (state_reg == ST_IDLE) && s_tvalid;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP: begin
                if (sts.walk_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (sts.in_op)
                        dsm_pkg::OP_PUSH: state_next = ST_LOOKUP;
                        dsm_pkg::OP_POP:  state_next = sts.fill_zero ? ST_FINISH : ST_LOOKUP;
                        default:          state_next = ST_WALK;
                    endcase
                end
            end
            ST_LOOKUP: begin
                state_next = ST_FINISH;
            end
            ST_WALK: begin
                if (sts.walk_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_SWEEP;
            end
        endcase
    end

    // State register; reset starts the mark sweep.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SWEEP;
        end else begin
            state_reg <= state_next;
        end
    end

    // Commands to the datapath.
    assign cmd.take   = take;
    assign cmd.lookup = (state_reg == ST_LOOKUP);
    assign cmd.walk   = (state_reg == ST_WALK);
    assign cmd.sweep  = (state_reg == ST_SWEEP);
    assign cmd.load   = (state_reg == ST_FINISH) && sts.out_free;

    assign s_tready = (state_reg == ST_IDLE);

endmodule
`default_nettype wire

// ----- hw/rtl/dsm_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsm_datapath
// Datapath of the deduplicating stack: entry and mark memories, fill count,
// walk counter, result registers and the output register.
// ----------------------------------------------------------------------------
module dsm_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [dsm_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic      [dsm_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire dsm_pkg::dsm_cmd_t               cmd,
    output dsm_pkg::dsm_sts_t                    sts
);

    // Fields of the incoming item.
    dsm_pkg::dsm_op_t                in_op;
    logic [dsm_pkg::VALUE_W-1:0]     in_value;
    logic [dsm_pkg::LIMIT_W-1:0]     in_limit;
    logic [dsm_pkg::IDX_W-1:0]       in_limit_clamped;

    assign in_op    = dsm_pkg::dsm_op_t'(s_tdata[1:0]);
    assign in_value = s_tdata[11:2];
    assign in_limit = s_tdata[22:12];

    // Init never clears beyond the value range.
    assign in_limit_clamped =
        (dsm_pkg::IDX_W'(in_limit) > dsm_pkg::IDX_W'(dsm_pkg::VALUE_RANGE)) ?
        dsm_pkg::IDX_W'(dsm_pkg::VALUE_RANGE) : dsm_pkg::IDX_W'(in_limit);

    // Registers.
    dsm_pkg::dsm_op_t                op_reg;
    logic [dsm_pkg::VALUE_W-1:0]     value_reg;
    logic [dsm_pkg::IDX_W-1:0]       limit_reg;
    logic [dsm_pkg::VALUE_W-1:0]     popped_reg;
    logic                            added_reg;
    logic [dsm_pkg::STATUS_W-1:0]    status_reg;
    logic [dsm_pkg::FILL_W-1:0]      fill_reg;
    logic [dsm_pkg::FILL_W-1:0]      fill_next;
    logic [dsm_pkg::IDX_W-1:0]       idx_reg;
    logic [dsm_pkg::IDX_W-1:0]       idx_next;
    logic                            pend_reg;
    logic                            pend_next;
    logic                            m_tvalid_reg;
    logic [dsm_pkg::OUT_DATA_W-1:0]  m_tdata_reg;

    // Memory ports.
    logic                            ent_we;
    logic [dsm_pkg::STK_AW-1:0]      ent_waddr;
    logic [dsm_pkg::STK_AW-1:0]      ent_raddr;
    logic [dsm_pkg::VALUE_W-1:0]     ent_rdata;
    logic                            mark_we;
    logic [dsm_pkg::VAL_AW-1:0]      mark_waddr;
    logic                            mark_wdata;
    logic                            mark_rdata;

    // Derived conditions.
    logic                            fill_zero;
    logic                            stack_full;
    logic                            value_in_range;
    logic                            push_new;
    logic                            push_add;
    logic                            walk_issue;
    logic                            walk_limit_wr;
    logic [dsm_pkg::IDX_W-1:0]       walk_limit;
    logic                            walk_done;
    logic                            walk_marks;

    assign fill_zero      = (fill_reg == '0);
    assign stack_full     = (fill_reg == dsm_pkg::FILL_W'(dsm_pkg::STACK_DEPTH));
    assign value_in_range =
        (dsm_pkg::IDX_W'(value_reg) < dsm_pkg::IDX_W'(dsm_pkg::VALUE_RANGE));
    assign push_new       = value_in_range && !mark_rdata;
    assign push_add       = cmd.lookup && (op_reg == dsm_pkg::OP_PUSH) &&
                            push_new && !stack_full;

    // Walk bookkeeping: a clear reads stored entries, an init or sweep
    // steps through mark addresses up to its limit.
    assign walk_marks    = cmd.sweep || (op_reg == dsm_pkg::OP_INIT);
    assign walk_limit    = cmd.sweep ? dsm_pkg::IDX_W'(dsm_pkg::VALUE_RANGE) : limit_reg;
    assign walk_limit_wr = (idx_reg < walk_limit);
    assign walk_issue    = (idx_reg < dsm_pkg::IDX_W'(fill_reg));
    assign walk_done     = walk_marks ? !walk_limit_wr : (!walk_issue && !pend_reg);

    // Entry memory addressing.
    assign ent_raddr = cmd.take ? dsm_pkg::STK_AW'(fill_reg - dsm_pkg::FILL_W'(1)) :
                                  dsm_pkg::STK_AW'(idx_reg);
    assign ent_we    = push_add;
    assign ent_waddr = dsm_pkg::STK_AW'(fill_reg);

    // Mark memory write selection.
    always_comb begin
        mark_we    = 1'b0;
        mark_waddr = dsm_pkg::VAL_AW'(idx_reg);
        mark_wdata = 1'b0;
        if (push_add) begin
            mark_we    = 1'b1;
            mark_waddr = dsm_pkg::VAL_AW'(value_reg);
            mark_wdata = 1'b1;
        end else if (cmd.lookup && (op_reg == dsm_pkg::OP_POP)) begin
            mark_we    = 1'b1;
            mark_waddr = dsm_pkg::VAL_AW'(ent_rdata);
        end else if (cmd.walk && !walk_marks && pend_reg) begin
            mark_we    = 1'b1;
            mark_waddr = dsm_pkg::VAL_AW'(ent_rdata);
        end else if ((cmd.sweep || cmd.walk) && walk_marks && walk_limit_wr) begin
            mark_we    = 1'b1;
            mark_waddr = dsm_pkg::VAL_AW'(idx_reg);
        end
    end

    dsm_ram #(
        .WIDTH (dsm_pkg::VALUE_W),
        .DEPTH (dsm_pkg::STACK_DEPTH)
    ) u_entries (
        .clk     (aclk),
        .wr_en   (ent_we),
        .wr_addr (ent_waddr),
        .wr_data (value_reg),
        .rd_addr (ent_raddr),
        .rd_data (ent_rdata)
    );

    dsm_ram #(
        .WIDTH (1),
        .DEPTH (dsm_pkg::VALUE_RANGE)
    ) u_marks (
        .clk     (aclk),
        .wr_en   (mark_we),
        .wr_addr (mark_waddr),
        .wr_data (mark_wdata),
        .rd_addr (dsm_pkg::VAL_AW'(in_value)),
        .rd_data (mark_rdata)
    );

    // Fill count, walk counter and read-pending flag.
    always_comb begin
        fill_next = fill_reg;
        idx_next  = idx_reg;
        pend_next = 1'b0;
        if (cmd.take) begin
            idx_next = '0;
        end else if (push_add) begin
            fill_next = fill_reg + dsm_pkg::FILL_W'(1);
        end else if (cmd.lookup && (op_reg == dsm_pkg::OP_POP)) begin
            fill_next = fill_reg - dsm_pkg::FILL_W'(1);
        end else if (cmd.walk || cmd.sweep) begin
            if (walk_marks) begin
                if (walk_limit_wr) begin
                    idx_next = idx_reg + dsm_pkg::IDX_W'(1);
                end
            end else begin
                pend_next = walk_issue;
                if (walk_issue) begin
                    idx_next = idx_reg + dsm_pkg::IDX_W'(1);
                end
            end
            if (cmd.walk && walk_done) begin
                fill_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            idx_reg  <= '0;
            pend_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            idx_reg  <= idx_next;
            pend_reg <= pend_next;
        end
    end

    // Item latch and result fields.
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            op_reg     <= in_op;
            value_reg  <= in_value;
            limit_reg  <= in_limit_clamped;
            popped_reg <= '0;
            added_reg  <= 1'b0;
            status_reg <= ((in_op == dsm_pkg::OP_POP) && fill_zero) ?
                          dsm_pkg::STS_UNDERFLOW : dsm_pkg::STS_OK;
        end else if (cmd.lookup) begin
            if (op_reg == dsm_pkg::OP_POP) begin
                popped_reg <= ent_rdata;
            end else if (push_new) begin
                if (stack_full) begin
                    status_reg <= dsm_pkg::STS_OVERFLOW;
                end else begin
                    added_reg <= 1'b1;
                end
            end
        end
    end

    // Output register; it frees up when the receiver takes the item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_tdata_reg <= {dsm_pkg::LEVEL_W'(fill_reg), status_reg, added_reg, popped_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Status to the controller.
    assign sts.in_op     = in_op;
    assign sts.fill_zero = fill_zero;
    assign sts.walk_done = walk_done;
    assign sts.out_free  = !m_tvalid_reg || m_tready;

endmodule
`default_nettype wire

// ----- hw/rtl/dedup_stack_with_membership.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dedup_stack_with_membership
// LIFO worklist of values with one membership mark per value.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one command item per handshake: push, pop, clear of
//   the stored entries, or init of the marks below a limit. The m_ channel
//   returns exactly one result item per command: popped value, added flag,
//   status and the fill level after the command.
//   Push and pop each take one read of the mark or entry memory followed by
//   one write; the result is then loaded into the output register. A pop
//   from an empty stack skips the read and reports an underflow.
//   Clear reads each stored entry once through the entry memory port and
//   clears the mark of each; init writes one mark a cycle up to the limit.
//   s_tready is low while a command is in progress.
//   After reset the block clears all marks, one per cycle, and holds
//   s_tready low until the sweep is done. The stack starts empty.
//   The output register holds a result until m_tready takes it; the next
//   item may be accepted meanwhile, but its result waits until the output
//   register is free.
// ----------------------------------------------------------------------------
module dedup_stack_with_membership (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // s_tdata fields, lowest bit first: cmd[1:0], value[11:2],
    // init_limit[22:12], zero [23].
    input  wire logic [dsm_pkg::IN_DATA_W-1:0]      s_tdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // m_tdata fields, lowest bit first: popped_value[9:0], was_added[10],
    // status[12:11], fill_level[23:13].
    output logic      [dsm_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready
);

    dsm_pkg::dsm_cmd_t cmd;
    dsm_pkg::dsm_sts_t sts;

    dsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dsm_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

`ifndef SYNTH
    // The fill level never exceeds the stack depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[23:13] <= dsm_pkg::LEVEL_W'(dsm_pkg::STACK_DEPTH)))
        else $error("fill level above stack depth");

    // An overflow stores nothing and only happens on a full stack.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[12:11] == dsm_pkg::STS_OVERFLOW)) |->
        (!m_tdata[10] && (m_tdata[23:13] == dsm_pkg::LEVEL_W'(dsm_pkg::STACK_DEPTH))))
        else $error("overflow reported with a stored value or a non-full stack");

    // An underflow leaves the stack empty and returns a zero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[12:11] == dsm_pkg::STS_UNDERFLOW)) |->
        ((m_tdata[9:0] == '0) && (m_tdata[23:13] == '0)))
        else $error("underflow reported on a non-empty stack");

    // A new result is only loaded when the previous one has been taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire
